FILE: sv/shp_pkg.sv
// shp_pkg: shared types and constants of the 3x3 sharpen filter.
// No dependencies; imported by shp_front, shp_back and the top level.
package shp_pkg;

  localparam int SHP_CH_W       = 8;
  localparam int SHP_CHANS      = 3;
  localparam int SHP_MAX_WIDTH  = 2048;
  localparam int SHP_MAX_HEIGHT = 4096;
  localparam int SHP_CMD_DEPTH  = 4;
  localparam int SHP_OUT_DEPTH  = 4;

  // configuration port
  localparam int SHP_CFG_DW = 13;
  localparam int SHP_CFG_IW = 2;

  localparam logic [11:0] SHP_WIDTH_RST  = 12'd640;
  localparam logic [12:0] SHP_HEIGHT_RST = 13'd480;
  localparam logic        SHP_MODE_RST   = 1'b1;

  typedef enum logic [SHP_CFG_IW-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_CHANNEL_MODE = 2'd2
  } cfg_idx_e;

  // one pixel, channel 0 in the low byte
  typedef logic [SHP_CHANS-1:0][SHP_CH_W-1:0] px_t;

  typedef struct packed {
    logic [7:0] pixel_ch0;
    logic [7:0] pixel_ch1;
    logic [7:0] pixel_ch2;
    logic       flush;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_ch0;
    logic [7:0] out_ch1;
    logic [7:0] out_ch2;
    logic       frame_last;
  } pix_out_t;

  // per-pixel decisions made by the front end
  typedef struct packed {
    logic top_en;   // row above exists
    logic mid_en;   // middle row exists
    logic restart;  // first column of a row
    logic emit;     // a result leaves for this pixel
    logic last;     // that result ends the frame
  } cmd_flags_t;

endpackage

FILE: sv/shp_fifo.sv
// shp_fifo: small register-based FIFO with fill count.
// Depends on nothing; used for the command queue and the result queue.
module shp_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [Width-1:0]           rdata_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] store_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = store_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: sv/shp_front.sv
// shp_front: raster position tracking and per-pixel classification.
// Depends on shp_pkg; feeds the command queue ahead of shp_back.
module shp_front import shp_pkg::*; #(
  parameter int MAX_WIDTH  = SHP_MAX_WIDTH,
  parameter int MAX_HEIGHT = SHP_MAX_HEIGHT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  pix_in_t                      in_i,
  input  logic [11:0]                  frame_width_i,
  input  logic [12:0]                  frame_height_i,
  output logic [$clog2(MAX_WIDTH)-1:0] cmd_col_o,
  output px_t                          cmd_px_o,
  output cmd_flags_t                   cmd_flags_o
);

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int WCntW = $clog2(MAX_WIDTH + 1);
  localparam int RowW  = $clog2(MAX_HEIGHT + 3);

  logic [ColW-1:0]  col_q, col_d, col_cur;
  logic [RowW-1:0]  row_q, row_d, row_cur;
  logic [WCntW-1:0] w_sat, col_inc;
  logic [RowW-1:0]  h_sat;
  logic             wrap, restart;

  // zero size means one, oversize saturates
  always_comb begin
    priority if (frame_width_i == '0) begin
      w_sat = WCntW'(1);
    end else if (32'(frame_width_i) > 32'(MAX_WIDTH)) begin
      w_sat = WCntW'(MAX_WIDTH);
    end else begin
      w_sat = WCntW'(frame_width_i);
    end
    priority if (frame_height_i == '0) begin
      h_sat = RowW'(1);
    end else if (32'(frame_height_i) > 32'(MAX_HEIGHT)) begin
      h_sat = RowW'(MAX_HEIGHT);
    end else begin
      h_sat = RowW'(frame_height_i);
    end
  end

  // column left over from a wider frame wraps to the next row
  assign wrap    = (WCntW'(col_q) >= w_sat);
  assign col_cur = wrap ? '0 : col_q;
  assign row_cur = wrap ? row_q + RowW'(1) : row_q;
  assign restart = (col_cur == '0);
  assign col_inc = WCntW'(col_cur) + WCntW'(1);

  always_comb begin
    cmd_col_o           = col_cur;
    cmd_flags_o.top_en  = (row_cur >= RowW'(2));
    cmd_flags_o.mid_en  = (row_cur != '0);
    cmd_flags_o.restart = restart;
    cmd_flags_o.emit    = restart ? (row_cur >= RowW'(2) && row_cur < h_sat + RowW'(2))
                                  : (row_cur != '0 && row_cur < h_sat + RowW'(1));
    cmd_flags_o.last    = restart && (row_cur == h_sat + RowW'(1));
    if (in_i.flush || row_cur >= h_sat) begin
      cmd_px_o = '0;
    end else begin
      cmd_px_o = {in_i.pixel_ch2, in_i.pixel_ch1, in_i.pixel_ch0};
    end
  end

  always_comb begin
    priority if (restart && row_cur >= h_sat + RowW'(1)) begin
      col_d = '0;
      row_d = '0;
    end else if (col_inc >= w_sat) begin
      col_d = '0;
      row_d = row_cur + RowW'(1);
    end else begin
      col_d = ColW'(col_inc);
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

FILE: sv/shp_back.sv
// shp_back: line store, 3x3 window and sharpen arithmetic.
// Depends on shp_pkg; drains the command queue, fills the result queue.
module shp_back import shp_pkg::*; #(
  parameter int MAX_WIDTH = SHP_MAX_WIDTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 channel_mode_i,
  input  logic                                 cmd_empty_i,
  output logic                                 cmd_pop_o,
  input  logic [$clog2(MAX_WIDTH)-1:0]         cmd_col_i,
  input  px_t                                  cmd_px_i,
  input  cmd_flags_t                           cmd_flags_i,
  input  logic [$clog2(SHP_OUT_DEPTH+1)-1:0]   out_count_i,
  input  logic                                 out_full_i,
  output logic                                 out_push_o,
  output pix_out_t                             out_data_o
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int OutW = $clog2(SHP_OUT_DEPTH + 3);

  typedef struct packed {
    px_t above;
    px_t middle;
  } line_t;

  line_t           line_mem_q [MAX_WIDTH];
  line_t           mem_rd_q, fwd_data_q, raw, wr_data;
  logic            fwd_q, fwd_d;

  logic            a_vld_q;
  logic [ColW-1:0] a_col_q;
  px_t             a_px_q;
  cmd_flags_t      a_flags_q;

  px_t             new_col [3];
  px_t             wc1_q [3];
  px_t             wc2_q [3];

  logic            b_vld_q, b_last_q;
  px_t             b_use_q [3][3];

  logic [OutW-1:0] outstanding;

  function automatic logic [7:0] sharpen(input logic [7:0] ctr, input logic [10:0] nsum);
    logic [12:0] pos;
    logic [12:0] neg;
    logic [12:0] diff;
    pos  = (13'(ctr) << 4) + (13'(ctr) << 3);
    neg  = {1'b0, nsum, 1'b0};
    diff = pos - neg;
    if (pos < neg) begin
      return 8'd0;
    end else if (diff[12:11] != 2'b00) begin
      return 8'd255;
    end
    return diff[10:3];
  endfunction

  // credit check: every item that may still produce a result owns a queue slot
  assign outstanding = OutW'(out_count_i) + OutW'(a_vld_q && a_flags_q.emit) + OutW'(b_vld_q);
  assign cmd_pop_o   = !cmd_empty_i && (outstanding < OutW'(SHP_OUT_DEPTH));

  // back-to-back hits on one column (width 1) bypass the memory
  assign fwd_d   = cmd_pop_o && a_vld_q && (a_col_q == cmd_col_i);
  assign raw     = fwd_q ? fwd_data_q : mem_rd_q;
  assign wr_data = '{above: raw.middle, middle: a_px_q};

  always_comb begin
    new_col[0] = a_flags_q.top_en ? raw.above  : '0;
    new_col[1] = a_flags_q.mid_en ? raw.middle : '0;
    new_col[2] = a_px_q;
  end

  always_ff @(posedge clk_i) begin
    if (a_vld_q) begin
      line_mem_q[a_col_q] <= wr_data;
    end
    if (cmd_pop_o) begin
      mem_rd_q <= line_mem_q[cmd_col_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      a_col_q    <= cmd_col_i;
      a_px_q     <= cmd_px_i;
      a_flags_q  <= cmd_flags_i;
      fwd_data_q <= wr_data;
    end
    if (a_vld_q && a_flags_q.emit) begin
      b_last_q <= a_flags_q.last;
      for (int r = 0; r < 3; r++) begin
        b_use_q[r][0] <= wc1_q[r];
        b_use_q[r][1] <= wc2_q[r];
        b_use_q[r][2] <= a_flags_q.restart ? '0 : new_col[r];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      fwd_q   <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        wc1_q[r] <= '0;
        wc2_q[r] <= '0;
      end
    end else begin
      a_vld_q <= cmd_pop_o;
      b_vld_q <= a_vld_q && a_flags_q.emit;
      if (cmd_pop_o) begin
        fwd_q <= fwd_d;
      end
      if (a_vld_q) begin
        for (int r = 0; r < 3; r++) begin
          wc1_q[r] <= a_flags_q.restart ? '0 : wc2_q[r];
          wc2_q[r] <= new_col[r];
        end
      end
    end
  end

  // sharpen from the registered window
  always_comb begin
    logic [10:0] nsum [SHP_CHANS];
    logic [7:0]  res  [SHP_CHANS];
    for (int k = 0; k < SHP_CHANS; k++) begin
      nsum[k] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (!(r == 1 && c == 1)) begin
            nsum[k] = nsum[k] + 11'(b_use_q[r][c][k]);
          end
        end
      end
      res[k] = sharpen(b_use_q[1][1][k], nsum[k]);
    end
    out_push_o            = b_vld_q;
    out_data_o.out_ch0    = res[0];
    out_data_o.out_ch1    = channel_mode_i ? res[1] : b_use_q[1][1][1];
    out_data_o.out_ch2    = channel_mode_i ? res[2] : b_use_q[1][1][2];
    out_data_o.frame_last = b_last_q;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> !out_full_i) else $error("result queue overflow");

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding <= OutW'(SHP_OUT_DEPTH)) else $error("credit count exceeded");

  a_pop_fills_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> a_vld_q) else $error("popped command lost");

  a_fwd_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_vld_q && fwd_q) |-> $past(a_vld_q)) else $error("bypass without writer");

endmodule

FILE: sv/sharpen_3x3_filter_top.sv
// sharpen_3x3_filter_top: streaming 3x3 sharpen filter, top level.
// Depends on shp_pkg, shp_fifo, shp_front and shp_back.
//
// Usage:
//  - Input side is a queue: drive in_data_i and push; a transfer happens
//    at a rising edge with push high and full low.
//  - Output side is a queue: while empty is low the oldest result sits on
//    out_data_o; a transfer happens at a rising edge with pop high.
//  - Config: cfg_we_i writes cfg_data_i into register cfg_idx_i
//    (0 frame width, 1 frame height, 2 channel mode). Write only while idle.
//  - Feed pixels in raster order, then width+1 flush items to drain the
//    last row. Result n belongs to the pixel width+1 items before it.
// Timing:
//  - Throughput 1 pixel per cycle while the result queue has free credit,
//    set by the line store that takes one read and one write per cycle; a
//    pixel's read overlaps the write of the pixel before it.
//  - The item that releases a result passes the command queue, the read
//    stage and the window stage before the result enters the output queue.
//  - Reset clears counters, window and queues; config returns to
//    640 x 480, all channels filtered. Line store needs no clearing.
//  - A stalled receiver fills the 4-entry result queue, then the command
//    queue; full is the command queue's own full flag.
module sharpen_3x3_filter_top import shp_pkg::*; #(
  parameter int MAX_WIDTH  = SHP_MAX_WIDTH,
  parameter int MAX_HEIGHT = SHP_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input queue
  input  logic                  push,
  input  pix_in_t               in_data_i,
  output logic                  full,
  // output queue
  output logic                  empty,
  input  logic                  pop,
  output pix_out_t              out_data_o,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [SHP_CFG_IW-1:0] cfg_idx_i,
  input  logic [SHP_CFG_DW-1:0] cfg_data_i
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int CmdW = ColW + $bits(px_t) + $bits(cmd_flags_t);
  localparam int OutW = $bits(pix_out_t);

  // config registers
  logic [11:0] frame_width_q;
  logic [12:0] frame_height_q;
  logic        channel_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= SHP_WIDTH_RST;
      frame_height_q <= SHP_HEIGHT_RST;
      channel_mode_q <= SHP_MODE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[11:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[12:0];
        CFG_CHANNEL_MODE: channel_mode_q <= cfg_data_i[0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // front end: position tracking and classification
  logic            in_xfer;
  logic [ColW-1:0] fr_col;
  px_t             fr_px;
  cmd_flags_t      fr_flags;

  assign in_xfer = push && !full;

  shp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_xfer),
    .in_i           (in_data_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .cmd_col_o      (fr_col),
    .cmd_px_o       (fr_px),
    .cmd_flags_o    (fr_flags)
  );

  // command queue between front and back
  logic [CmdW-1:0] cmd_wdata, cmd_rdata;
  logic            cmd_empty, cmd_pop;
  logic [ColW-1:0] hd_col;
  px_t             hd_px;
  cmd_flags_t      hd_flags;

  assign cmd_wdata = {fr_col, fr_px, fr_flags};
  assign {hd_col, hd_px, hd_flags} = cmd_rdata;

  shp_fifo #(
    .Width (CmdW),
    .Depth (SHP_CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_xfer),
    .wdata_i (cmd_wdata),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rdata),
    .full_o  (full),
    .empty_o (cmd_empty),
    .count_o ()
  );

  // back end: line store, window, arithmetic
  logic                               res_push, res_full;
  pix_out_t                           res_data;
  logic [$clog2(SHP_OUT_DEPTH+1)-1:0] res_count;
  logic [OutW-1:0]                    res_rdata;

  shp_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .channel_mode_i (channel_mode_q),
    .cmd_empty_i    (cmd_empty),
    .cmd_pop_o      (cmd_pop),
    .cmd_col_i      (hd_col),
    .cmd_px_i       (hd_px),
    .cmd_flags_i    (hd_flags),
    .out_count_i    (res_count),
    .out_full_i     (res_full),
    .out_push_o     (res_push),
    .out_data_o     (res_data)
  );

  // result queue doubles as the output register
  shp_fifo #(
    .Width (OutW),
    .Depth (SHP_OUT_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_data),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .full_o  (res_full),
    .empty_o (empty),
    .count_o (res_count)
  );

  assign out_data_o = res_rdata;

endmodule

FILE: tb/sharpen_tb_pkg.sv
`timescale 1ns / 100ps
// sharpen_tb_pkg: pixel-accurate scoreboard for the 3x3 sharpen filter.
// Depends on shp_pkg for the payload structs and config indexes.
package sharpen_tb_pkg;
  import shp_pkg::*;

  class sharpen_scoreboard;
    // register copies
    logic [11:0] width_reg = SHP_WIDTH_RST;
    logic [12:0] height_reg = SHP_HEIGHT_RST;
    logic mode_reg = SHP_MODE_RST;

    // line stores, 3x3 window (index row*3+col, row 0 on top), position
    px_t above_line[SHP_MAX_WIDTH];
    px_t middle_line[SHP_MAX_WIDTH];
    px_t win[9];
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;

    pix_out_t sharpened_q[$];
    int unsigned n_bad = 0;

    function new();
      foreach (win[i]) win[i] = '0;
      foreach (above_line[i]) begin
        above_line[i] = '0;
        middle_line[i] = '0;
      end
    endfunction

    function void write_reg(cfg_idx_e idx, int unsigned v);
      case (idx)
        CFG_FRAME_WIDTH: width_reg = v[11:0];
        CFG_FRAME_HEIGHT: height_reg = v[12:0];
        CFG_CHANNEL_MODE: mode_reg = v[0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return sharpened_q.size();
    endfunction

    // 24*center - 2*neighbours, floored /8, clamped to a byte
    function logic [7:0] sharpen_chan(px_t taps[9], int ch);
      int acc;
      acc = 0;
      for (int i = 0; i < 9; i++)
        acc += (i == 4) ? 24 * int'(taps[i][ch]) : -2 * int'(taps[i][ch]);
      if (acc < 0) return 8'd0;
      acc = acc / 8;
      return (acc > 255) ? 8'd255 : acc[7:0];
    endfunction

    function void note_pixel(pix_in_t it);
      int unsigned w, h, ic, ir;
      px_t px, top, mid;
      px_t taps[9];
      bit emit, is_last;
      pix_out_t res;
      w = width_reg;
      h = height_reg;
      if (w == 0) w = 1;
      if (w > SHP_MAX_WIDTH) w = SHP_MAX_WIDTH;
      if (h == 0) h = 1;
      if (h > SHP_MAX_HEIGHT) h = SHP_MAX_HEIGHT;
      ic = col_pos;
      ir = row_pos;
      if (ic >= w) begin
        ic = 0;
        ir++;
      end
      if (it.flush || ir >= h) begin
        px = '0;
      end else begin
        px[0] = it.pixel_ch0;
        px[1] = it.pixel_ch1;
        px[2] = it.pixel_ch2;
      end
      top = (ir >= 2) ? above_line[ic] : '0;
      mid = (ir >= 1) ? middle_line[ic] : '0;
      above_line[ic] = middle_line[ic];
      middle_line[ic] = px;
      emit = 1'b0;
      is_last = 1'b0;
      if (ic == 0) begin
        // row start closes the previous row with a zero right column
        for (int r = 0; r < 3; r++) begin
          taps[r*3] = win[r*3+1];
          taps[r*3+1] = win[r*3+2];
          taps[r*3+2] = '0;
          win[r*3] = '0;
          win[r*3+1] = '0;
        end
        if (ir >= 2 && ir - 2 < h) begin
          emit = 1'b1;
          is_last = (ir - 2 == h - 1);
        end
      end else begin
        for (int r = 0; r < 3; r++) begin
          win[r*3] = win[r*3+1];
          win[r*3+1] = win[r*3+2];
        end
        if (ir >= 1 && ir - 1 < h) emit = 1'b1;
      end
      win[2] = top;
      win[5] = mid;
      win[8] = px;
      if (ic != 0) taps = win;
      if (ic == 0 && ir >= h + 1) begin
        ic = 0;
        ir = 0;
      end else begin
        ic++;
        if (ic >= w) begin
          ic = 0;
          ir++;
        end
      end
      col_pos = ic;
      row_pos = ir;
      if (!emit) return;
      res.out_ch0 = sharpen_chan(taps, 0);
      if (mode_reg) begin
        res.out_ch1 = sharpen_chan(taps, 1);
        res.out_ch2 = sharpen_chan(taps, 2);
      end else begin
        res.out_ch1 = taps[4][1];
        res.out_ch2 = taps[4][2];
      end
      res.frame_last = is_last;
      sharpened_q.push_back(res);
    endfunction

    function void check_pixel(pix_out_t got);
      pix_out_t want;
      if (sharpened_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected output pixel %h, none pending", got);
        return;
      end
      want = sharpened_q.pop_front();
      if (got.out_ch0 !== want.out_ch0 || got.out_ch1 !== want.out_ch1 ||
          got.out_ch2 !== want.out_ch2 || got.frame_last !== want.frame_last) begin
        n_bad++;
        if (n_bad <= 10)
          $display("pixel mismatch: want %h %h %h last %b, got %h %h %h last %b",
                   want.out_ch0, want.out_ch1, want.out_ch2, want.frame_last,
                   got.out_ch0, got.out_ch1, got.out_ch2, got.frame_last);
      end
    endfunction
  endclass

endpackage

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking testbench of sharpen_3x3_filter_top.
// Uses shp_pkg and sharpen_tb_pkg; random frames, stalls on both sides.
module tb_top;
  import shp_pkg::*;
  import sharpen_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  pix_in_t in_data = '0;
  logic full;
  logic empty;
  logic pop = 1'b0;
  pix_out_t out_data;
  logic cfg_we = 1'b0;
  logic [SHP_CFG_IW-1:0] cfg_idx = CFG_FRAME_WIDTH;
  logic [SHP_CFG_DW-1:0] cfg_data = '0;

  sharpen_scoreboard sb = new();

  // effective frame size and mode as the block sees them
  int unsigned cur_w = 640;
  int unsigned cur_h = 480;
  bit cur_m = 1'b1;

  // idling knobs shared by the two sides
  int unsigned tx_gap_pct = 0;
  int unsigned rx_gap_pct = 0;
  bit quiet = 1'b0;     // final part: no idling at all
  bit hold_req = 1'b0;  // asks the result side for one long hold-off

  always #4 clk_i = ~clk_i;

  sharpen_3x3_filter_top dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .in_data_i (in_data),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .out_data_o(out_data),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // Random pixel; channels lean toward 0 and 255 to hit both clamps.
  function automatic pix_in_t rand_px(bit fl);
    pix_in_t p;
    logic [7:0] ch[3];
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 7))
        0: ch[i] = 8'h00;
        1: ch[i] = 8'hFF;
        default: ch[i] = 8'($urandom);
      endcase
    end
    p.pixel_ch0 = ch[0];
    p.pixel_ch1 = ch[1];
    p.pixel_ch2 = ch[2];
    p.flush = fl;
    return p;
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 35;
    endcase
  endfunction

  // One input transfer. push is left high on return so back-to-back items
  // keep it asserted; any gap lowers it first.
  task automatic offer(input pix_in_t it);
    if (!quiet && $urandom_range(0, 99) < tx_gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_data <= it;
    push <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_pixel(it);
  endtask

  // Stop sending, let every expected pixel drain, then give the pipeline
  // (command queue, read stage, window stage) time to finish items that
  // release no result.
  task automatic settle(input int unsigned tail);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  // Writes all three registers back to back; caller makes sure the block
  // is idle. Raw values go out as given, saturation is the block's job.
  task automatic set_frame(input int unsigned w, input int unsigned h, input bit m);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_FRAME_WIDTH;
    cfg_data <= SHP_CFG_DW'(w);
    @(posedge clk_i);
    cfg_idx <= CFG_FRAME_HEIGHT;
    cfg_data <= SHP_CFG_DW'(h);
    @(posedge clk_i);
    cfg_idx <= CFG_CHANNEL_MODE;
    cfg_data <= SHP_CFG_DW'(m);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.write_reg(CFG_FRAME_WIDTH, w);
    sb.write_reg(CFG_FRAME_HEIGHT, h);
    sb.write_reg(CFG_CHANNEL_MODE, m);
    cur_w = (w == 0) ? 1 : ((w > SHP_MAX_WIDTH) ? SHP_MAX_WIDTH : w);
    cur_h = (h == 0) ? 1 : ((h > SHP_MAX_HEIGHT) ? SHP_MAX_HEIGHT : h);
    cur_m = m;
  endtask

  // Complete whatever frame is open: pixels while inside the frame, then
  // drain items until the position counters wrap back to the origin.
  task automatic finish_frame();
    while (sb.col_pos != 0 || sb.row_pos != 0)
      offer(rand_px(sb.row_pos >= cur_h));
  endtask

  // New size only between whole frames, never mid-row.
  task automatic reframe(input int unsigned w, input int unsigned h, input bit m);
    finish_frame();
    settle(12);
    set_frame(w, h, m);
  endtask

  // Well-formed frame: W*H pixels then W+1 drain items. With noise on, a
  // few pixels are flush items and a few drain items carry flush low.
  task automatic send_frame(input bit noisy);
    pix_in_t p;
    for (int i = 0; i < cur_w * cur_h; i++)
      offer(rand_px(noisy && $urandom_range(0, 24) == 0));
    for (int i = 0; i <= cur_w; i++) begin
      p = rand_px(1'b1);
      if (noisy && $urandom_range(0, 6) == 0) p.flush = 1'b0;
      offer(p);
    end
  endtask

  // Result side: checks every pop transfer, idles in bursts, and serves one
  // long hold-off on request so that the output queue and then the input
  // side back up.
  initial begin : result_side
    int unsigned hold_left;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) sb.check_pixel(out_data);
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 150;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < rx_gap_pct) begin
        hold_left = $urandom_range(0, 11);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    pix_in_t p;
    int unsigned fr, kind, k, n_items, w_raw, h_raw;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---
    // 3x3, all channels: ch0 is a lone bright center (clamps high, its
    // neighbours clamp to zero), ch1 is flat white, ch2 a dark center in a
    // white field (negative sum). One pixel arrives as a flush item.
    reframe(3, 3, 1'b1);
    for (int i = 0; i < 9; i++) begin
      p.pixel_ch0 = (i == 4) ? 8'hFF : 8'h00;
      p.pixel_ch1 = 8'hFF;
      p.pixel_ch2 = (i == 4) ? 8'h00 : 8'hFF;
      p.flush = (i == 1);
      offer(p);
    end
    repeat (4) offer(rand_px(1'b1));

    // 2x2, channel 0 only: ch1/ch2 pass through. Drain items carry flush
    // low with white samples, which must still count as zero.
    reframe(2, 2, 1'b0);
    repeat (4) offer(rand_px(1'b0));
    p = '{pixel_ch0: 8'hFF, pixel_ch1: 8'hFF, pixel_ch2: 8'hFF, flush: 1'b0};
    repeat (3) offer(p);

    // zero width and height behave as a 1x1 frame
    reframe(0, 0, 1'b1);
    offer(p);
    repeat (2) offer(rand_px(1'b1));

    // --- random frames ---
    fr = 0;
    n_items = 0;
    while (n_items < 800) begin
      fr++;
      tx_gap_pct = pick_pct();
      rx_gap_pct = pick_pct();
      if (fr == 6) begin
        // long receiver hold-off while the sender streams back to back
        reframe(16, 6, 1'($urandom));
        tx_gap_pct = 0;
        hold_req = 1'b1;
        send_frame(1'b0);
        n_items += cur_w * (cur_h + 1) + 1;
      end else begin
        if ($urandom_range(0, 9) < 7) begin
          k = $urandom_range(0, 19);
          w_raw = (k == 0) ? 0 : ((k < 4) ? $urandom_range(9, 40) : $urandom_range(1, 8));
          h_raw = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 5);
          reframe(w_raw, h_raw, 1'($urandom));
        end
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
          send_frame(1'b1);
          n_items += cur_w * (cur_h + 1) + 1;
        end else if (kind == 7) begin
          // short drain: the next items carry on from a shifted position
          k = cur_w * cur_h + $urandom_range(0, cur_w);
          for (int i = 0; i < k; i++) offer(rand_px(i >= cur_w * cur_h));
          n_items += k;
        end else if (kind == 8) begin
          // surplus drain items open the following frame
          send_frame(1'b1);
          k = $urandom_range(1, 4);
          repeat (k) offer(rand_px(1'b1));
          n_items += cur_w * (cur_h + 1) + 1 + k;
        end else if (cur_w * cur_h > 1) begin
          // change the size part way through a frame while idle, never growing it
          k = $urandom_range(1, cur_w * cur_h - 1);
          repeat (k) offer(rand_px(1'b0));
          settle(12);
          if (cur_w > 1 && $urandom_range(0, 1) == 0)
            set_frame($urandom_range(1, cur_w - 1), cur_h, cur_m);
          else
            set_frame(cur_w, $urandom_range(1, cur_h), cur_m);
          finish_frame();
          n_items += k + cur_w * 2;
        end else begin
          send_frame(1'b1);
          n_items += 3;
        end
      end
    end

    // --- final part, no idling ---
    quiet = 1'b1;
    repeat (3) begin
      reframe($urandom_range(1, 12), $urandom_range(1, 4), 1'($urandom));
      send_frame(1'b1);
    end

    settle(20);
    if (sb.n_bad == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Watchdog, far above the slowest legal run (~1k items with full gaps).
  initial begin : watchdog
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
